/* rtl/msar_pkg.sv */
`default_nettype none

package msar_pkg;

  localparam int CHANNELS   = 8;
  localparam int MAX_BITS   = 16;
  localparam int DATA_LINES = 8;

  localparam int WORD_W     = 16;
  localparam int LONG_W     = 10;
  localparam int SHORT_W    = 8;
  localparam int BITS_W     = 5;
  localparam int BITCNT_W   = 6;
  localparam int CHAN_W     = 3;
  localparam int DATA_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int BEAT_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONVERT_HIGH = 3'd0,
    REG_CONVERT_WAIT = 3'd1,
    REG_SAMPLE_DELAY = 3'd2,
    REG_CLOCK_HOLD   = 3'd3,
    REG_CLOCK_LOW    = 3'd4,
    REG_BITS         = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [LONG_W-1:0]  convert_high_ticks;
    logic [LONG_W-1:0]  convert_wait_ticks;
    logic [SHORT_W-1:0] sample_delay_ticks;
    logic [SHORT_W-1:0] clock_hold_ticks;
    logic [SHORT_W-1:0] clock_low_ticks;
    logic [BITS_W-1:0]  bits_per_sample;
  } cfg_t;

  typedef struct packed {
    logic                             convert_level;
    logic                             clock_level;
    logic                             busy;
    logic                             finish;
    logic [CHANNELS-1:0][WORD_W-1:0]  words;
  } rec_t;

endpackage

`default_nettype wire

/* rtl/msar_if.sv */
`default_nettype none

interface msar_in_if;
  logic                              valid;
  logic                              ready;
  logic                              start_req;
  logic [msar_pkg::DATA_W-1:0]       miso_bits;

  modport source (output valid, output start_req, output miso_bits, input ready);
  modport sink (input valid, input start_req, input miso_bits, output ready);
endinterface

interface msar_out_if;
  logic                              valid;
  logic                              ready;
  logic                              convert_level;
  logic                              clock_level;
  logic                              busy_res;
  logic                              word_valid;
  logic [msar_pkg::CHAN_W-1:0]       channel;
  logic [msar_pkg::WORD_W-1:0]       sample_value;
  logic                              last_word;

  modport source (output valid, output convert_level, output clock_level, output busy_res,
                  output word_valid, output channel, output sample_value, output last_word,
                  input ready);
  modport sink (input valid, input convert_level, input clock_level, input busy_res,
                input word_valid, input channel, input sample_value, input last_word,
                output ready);
endinterface

interface msar_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [msar_pkg::CFG_IDX_W-1:0]    index;
  logic [msar_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/msar_cfg.sv */
`default_nettype none

module msar_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  msar_cfg_if.sink            cfg_i,
  output msar_pkg::cfg_t      cfg_o
);

  msar_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.convert_high_ticks <= msar_pkg::LONG_W'(150);
      cfg_q.convert_wait_ticks <= msar_pkg::LONG_W'(100);
      cfg_q.sample_delay_ticks <= msar_pkg::SHORT_W'(10);
      cfg_q.clock_hold_ticks   <= msar_pkg::SHORT_W'(10);
      cfg_q.clock_low_ticks    <= msar_pkg::SHORT_W'(35);
      cfg_q.bits_per_sample    <= msar_pkg::BITS_W'(14);
    end else if (wr_en) begin
      case (msar_pkg::cfg_reg_e'(cfg_i.index))
        msar_pkg::REG_CONVERT_HIGH: cfg_q.convert_high_ticks <= cfg_i.data;
        msar_pkg::REG_CONVERT_WAIT: cfg_q.convert_wait_ticks <= cfg_i.data;
        msar_pkg::REG_SAMPLE_DELAY:
          cfg_q.sample_delay_ticks <= cfg_i.data[msar_pkg::SHORT_W-1:0];
        msar_pkg::REG_CLOCK_HOLD:
          cfg_q.clock_hold_ticks <= cfg_i.data[msar_pkg::SHORT_W-1:0];
        msar_pkg::REG_CLOCK_LOW:
          cfg_q.clock_low_ticks <= cfg_i.data[msar_pkg::SHORT_W-1:0];
        msar_pkg::REG_BITS:
          cfg_q.bits_per_sample <= cfg_i.data[msar_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/msar_seq.sv */
`default_nettype none

module msar_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire msar_pkg::cfg_t                cfg_i,
  input  wire logic                          accept_i,
  input  wire logic                          start_req_i,
  input  wire logic [msar_pkg::DATA_W-1:0]   miso_bits_i,
  output msar_pkg::rec_t                     rec_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CNV   = 3'd1;
  localparam logic [2:0] PH_WAIT  = 3'd2;
  localparam logic [2:0] PH_SETUP = 3'd3;
  localparam logic [2:0] PH_HOLD  = 3'd4;
  localparam logic [2:0] PH_LOW   = 3'd5;

  logic [2:0]                     phase_q, phase_d, cur_ph;
  logic [msar_pkg::LONG_W-1:0]    tick_q, tick_d, cur_tick, tick_inc, phase_len;
  logic [msar_pkg::BITS_W-1:0]    bit_q, bit_d, cur_bit;
  logic [msar_pkg::WORD_W-1:0]    shift_q [msar_pkg::CHANNELS];
  logic [msar_pkg::WORD_W-1:0]    shift_d [msar_pkg::CHANNELS];
  logic [msar_pkg::CHANNELS-1:0]  miso_ext;
  logic [msar_pkg::BITCNT_W-1:0]  bit_cnt, bit_next;
  logic                           launch, capture, phase_done, bit_last, finish;

  assign launch   = (phase_q == PH_IDLE) && start_req_i;
  assign cur_ph   = launch ? PH_CNV : phase_q;
  assign cur_tick = launch ? '0 : tick_q;
  assign cur_bit  = launch ? '0 : bit_q;
  assign capture  = (cur_ph == PH_HOLD) && (cur_tick == '0);
  assign miso_ext = msar_pkg::CHANNELS'(miso_bits_i);
  assign tick_inc = cur_tick + msar_pkg::LONG_W'(1);

  always_comb begin
    for (int k = 0; k < msar_pkg::CHANNELS; k++) begin
      if (launch) begin
        shift_d[k] = '0;
      end else if (capture) begin
        shift_d[k] = {shift_q[k][msar_pkg::WORD_W-2:0], miso_ext[k]};
      end else begin
        shift_d[k] = shift_q[k];
      end
    end
  end

  always_comb begin
    case (cur_ph)
      PH_CNV: begin
        phase_len = (cfg_i.convert_high_ticks == '0) ? msar_pkg::LONG_W'(1)
                                                      : cfg_i.convert_high_ticks;
      end
      PH_WAIT:  phase_len = cfg_i.convert_wait_ticks;
      PH_SETUP: begin
        phase_len = (cfg_i.sample_delay_ticks == '0) ? msar_pkg::LONG_W'(1)
                  : msar_pkg::LONG_W'(cfg_i.sample_delay_ticks);
      end
      PH_HOLD: begin
        phase_len = (cfg_i.clock_hold_ticks == '0) ? msar_pkg::LONG_W'(1)
                  : msar_pkg::LONG_W'(cfg_i.clock_hold_ticks);
      end
      default: begin
        phase_len = (cfg_i.clock_low_ticks == '0) ? msar_pkg::LONG_W'(1)
                  : msar_pkg::LONG_W'(cfg_i.clock_low_ticks);
      end
    endcase
  end

  always_comb begin
    if (cfg_i.bits_per_sample == '0) begin
      bit_cnt = msar_pkg::BITCNT_W'(1);
    end else if (msar_pkg::BITCNT_W'(cfg_i.bits_per_sample) >
                 msar_pkg::BITCNT_W'(msar_pkg::MAX_BITS)) begin
      bit_cnt = msar_pkg::BITCNT_W'(msar_pkg::MAX_BITS);
    end else begin
      bit_cnt = msar_pkg::BITCNT_W'(cfg_i.bits_per_sample);
    end
  end

  assign phase_done = tick_inc >= phase_len;
  assign bit_next   = msar_pkg::BITCNT_W'(cur_bit) + msar_pkg::BITCNT_W'(1);
  assign bit_last   = bit_next >= bit_cnt;

  always_comb begin
    phase_d = cur_ph;
    tick_d  = tick_inc;
    bit_d   = cur_bit;
    finish  = 1'b0;
    if (cur_ph == PH_IDLE) begin
      tick_d = tick_q;
    end else if (phase_done) begin
      tick_d = '0;
      case (cur_ph)
        PH_CNV:   phase_d = (cfg_i.convert_wait_ticks != '0) ? PH_WAIT : PH_SETUP;
        PH_WAIT:  phase_d = PH_SETUP;
        PH_SETUP: phase_d = PH_HOLD;
        PH_HOLD:  phase_d = PH_LOW;
        default: begin
          if (bit_last) begin
            finish  = 1'b1;
            phase_d = PH_IDLE;
            bit_d   = '0;
          end else begin
            bit_d   = bit_next[msar_pkg::BITS_W-1:0];
            phase_d = PH_SETUP;
          end
        end
      endcase
    end
  end

  always_comb begin
    rec_o.convert_level = (cur_ph == PH_CNV);
    rec_o.clock_level   = (cur_ph == PH_SETUP) || (cur_ph == PH_HOLD);
    rec_o.busy          = (cur_ph != PH_IDLE);
    rec_o.finish        = finish;
    for (int k = 0; k < msar_pkg::CHANNELS; k++) begin
      rec_o.words[k] = shift_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int k = 0; k < msar_pkg::CHANNELS; k++) begin
        shift_q[k] <= shift_d[k];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/msar_outq.sv */
`default_nettype none

module msar_outq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire msar_pkg::rec_t     rec_i,
  output logic                    ready_o,
  msar_out_if.source              out_o
);

  msar_pkg::rec_t               slot_q [2];
  msar_pkg::rec_t               head;
  logic                         wr_q, rd_q;
  logic [1:0]                   count_q, count_d;
  logic [msar_pkg::BEAT_W-1:0]  beat_q;
  logic                         fire, last_beat, pop;

  assign ready_o   = !count_q[1];
  assign head      = slot_q[rd_q];
  assign fire      = out_o.valid && out_o.ready;
  assign last_beat = !head.finish ||
                     (beat_q == msar_pkg::BEAT_W'(msar_pkg::CHANNELS - 1));
  assign pop       = fire && last_beat;
  assign count_d   = count_q + {1'b0, push_i} - {1'b0, pop};

  assign out_o.valid         = (count_q != 2'd0);
  assign out_o.convert_level = head.convert_level;
  assign out_o.clock_level   = head.clock_level;
  assign out_o.busy_res      = head.busy;
  assign out_o.word_valid    = head.finish;
  assign out_o.channel       = head.finish ? msar_pkg::CHAN_W'(beat_q) : '0;
  assign out_o.sample_value  = head.finish ? head.words[beat_q] : '0;
  assign out_o.last_word     = head.finish &&
                               (beat_q == msar_pkg::BEAT_W'(msar_pkg::CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
      beat_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q   <= !rd_q;
        beat_q <= '0;
      end else if (fire) begin
        beat_q <= beat_q + msar_pkg::BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= rec_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/multichannel_serial_adc_readout.sv */
`default_nettype none

// Conversion sequencer for a bank of serial ADCs that share one convert-start line and one
// serial clock, each with its own data line. Every accepted input transaction is one timing
// tick, one per clock cycle while input ready is high; sequencer state and capture shift
// registers update in the cycle of acceptance and each tick's pin levels enter a two-entry
// result queue. A tick normally yields one output transaction, the final tick of a conversion
// one per channel, kept queued until all are taken; input ready drops only while both queue
// entries are occupied. Delay registers are counted in ticks. The user must write them through
// the configuration channel while no conversion runs; the block itself does not enforce this.
module multichannel_serial_adc_readout (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  msar_in_if.sink      in_i,
  msar_out_if.source   out_o,
  msar_cfg_if.sink     cfg_i
);

  msar_pkg::cfg_t  cfg;
  msar_pkg::rec_t  rec;
  logic            accept;
  logic            queue_ready;

  assign in_i.ready = queue_ready;
  assign accept     = in_i.valid && queue_ready;

  msar_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  msar_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .start_req_i (in_i.start_req),
    .miso_bits_i (in_i.miso_bits),
    .rec_o       (rec)
  );

  msar_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .rec_i   (rec),
    .ready_o (queue_ready),
    .out_o   (out_o)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("Input stalled while the result queue is empty.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_word |->
      out_o.word_valid && out_o.channel == msar_pkg::CHAN_W'(msar_pkg::CHANNELS - 1))
    else $error("Last word marked on a wrong channel.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.busy_res |->
      !out_o.convert_level && !out_o.clock_level && !out_o.word_valid)
    else $error("Pin activity or word reported while idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.word_valid && !out_o.ready |=>
      out_o.valid && $stable(out_o.channel) && $stable(out_o.sample_value))
    else $error("Channel word changed while stalled.");
`endif

endmodule

`default_nettype wire
